FILE: rtl/assert_macros.svh
// assertion macros used by circle_point_stepper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under clock and active-low reset
`define CPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under clock and active-low reset
`define CPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cps_pkg.sv
// types, constants and the arctangent table of the circle point stepper
package cps_pkg;

  localparam int PHASE_BITS   = 16;
  localparam int COORD_BITS   = 32;
  localparam int CORDIC_STEPS = 16;

  localparam int IDX_W  = $clog2(CORDIC_STEPS);
  localparam int TURN_W = 32;
  localparam int XY_W   = 44;
  localparam int Z_W    = TURN_W + 2;

  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
  localparam logic signed [63:0] COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] COORD_LO = -COORD_HI - 64'sd1;

  typedef enum logic [1:0] {
    REQ_FROM_POINT = 2'd0,
    REQ_SET_ANGLE  = 2'd1,
    REQ_STEP_ANGLE = 2'd2
  } cps_kind_e;

  localparam logic [1:0] CFG_CENTRE_X = 2'd0;
  localparam logic [1:0] CFG_CENTRE_Y = 2'd1;
  localparam logic [1:0] CFG_RADIUS   = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        turn_amount;
  } cps_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               at_centre;
    logic               saturated;
  } cps_res_t;

  // control of one micro-rotation: sigma set means rotate counterclockwise
  typedef struct packed {
    logic             sigma;
    logic [IDX_W-1:0] idx;
  } cps_ctl_t;

  // atan(2^-i) in 1/2^32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/cps_cordic_unit.sv
// one shared cordic micro-rotation, used for both vectoring and rotation
module cps_cordic_unit (
  input  cps_pkg::cps_ctl_t                 ctl_i,
  input  logic signed [cps_pkg::XY_W-1:0]   x_i,
  input  logic signed [cps_pkg::XY_W-1:0]   y_i,
  input  logic signed [cps_pkg::Z_W-1:0]    z_i,
  output logic signed [cps_pkg::XY_W-1:0]   x_o,
  output logic signed [cps_pkg::XY_W-1:0]   y_o,
  output logic signed [cps_pkg::Z_W-1:0]    z_o
);
  import cps_pkg::*;

  logic signed [XY_W-1:0] sx;
  logic signed [XY_W-1:0] sy;
  logic signed [Z_W-1:0]  ang;

  // floor shifts and the table angle
  assign sx  = x_i >>> ctl_i.idx;
  assign sy  = y_i >>> ctl_i.idx;
  assign ang = $signed({2'b00, atan_turn(5'(ctl_i.idx))});

  // add or subtract by direction
  always_comb begin
    if (ctl_i.sigma) begin
      x_o = x_i - sy;
      y_o = y_i + sx;
      z_o = z_i - ang;
    end else begin
      x_o = x_i + sy;
      y_o = y_i - sx;
      z_o = z_i + ang;
    end
  end

endmodule

FILE: rtl/circle_point_stepper.sv
// circle point stepper: keeps a phase and reports centre + radius * (cos, sin)
//
// Usage: configure centre_x, centre_y and circle_radius through the cfg
// channel (index 0, 1, 2; cfg_ready_o is always high) while no request is in
// flight. Each request transaction on the in channel gives exactly one result
// transaction on the out channel, in order.
// Request kinds: set phase from the direction of a point seen from the centre,
// set phase to the negated angle, or step the phase back by the angle. Any
// other kind leaves the phase as it is and reports the current point.
// The cordic runs one micro-rotation per cycle on a single shared unit.
// An angle request passes from accept to result valid through setup, rotation
// init, 16 rotation steps, sign fix, the radius products for x and then y on
// the shared multiplier, the centre add with saturation and the hand-off to
// the output register. A point request first passes through normalize, the
// vectoring steps and the rounding of the phase.
// One request at a time: in_ready_o is high only when the sequencer is idle,
// and a new request may be accepted while the previous result still waits
// in the output register. If the receiver stalls, the finished result waits
// in the sequencer until the output register frees.
// Reset clears the phase, the sequencer state, the configuration registers and the output valid flag.
module circle_point_stepper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cps_pkg::cps_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cps_pkg::cps_res_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import cps_pkg::*;

  `include "assert_macros.svh"

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_NORM  = 4'd2;
  localparam logic [3:0] ST_VEC   = 4'd3;
  localparam logic [3:0] ST_ROUND = 4'd4;
  localparam logic [3:0] ST_RINIT = 4'd5;
  localparam logic [3:0] ST_ROT   = 4'd6;
  localparam logic [3:0] ST_FLIP  = 4'd7;
  localparam logic [3:0] ST_MULX  = 4'd8;
  localparam logic [3:0] ST_MULY  = 4'd9;
  localparam logic [3:0] ST_PLACE = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CORDIC_STEPS - 1);
  localparam logic [Z_W-1:0]   HALF_TURN = Z_W'(64'h8000_0000);

  // scale a 1/65536 turn amount to the phase width
  function automatic logic [PHASE_BITS-1:0] scale_amt(input logic [15:0] a);
    logic [PHASE_BITS+15:0] w;
    w = {a, {PHASE_BITS{1'b0}}};
    return w[PHASE_BITS+15:16];
  endfunction

  // centre plus rounded product, clamped; msb of the result is the clamp flag
  function automatic logic [32:0] place(input logic signed [31:0] c,
                                        input logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [63:0] v;
    r = (p + 64'sd536870912) >>> 30;
    v = $signed({{32{c[31]}}, c}) + r;
    if (v > COORD_HI) begin
      return {1'b1, COORD_HI[31:0]};
    end else if (v < COORD_LO) begin
      return {1'b1, COORD_LO[31:0]};
    end
    return {1'b0, v[31:0]};
  endfunction

  logic [3:0]             state_q, state_d;
  logic [IDX_W-1:0]       iter_q;
  logic [1:0]             kind_q;
  logic [15:0]            turn_q;
  logic [PHASE_BITS-1:0]  phase_q;
  logic signed [XY_W-1:0] x_q;
  logic signed [XY_W-1:0] y_q;
  logic signed [Z_W-1:0]  z_q;
  logic                   flip_q;
  logic                   hit_q;
  logic signed [63:0]     prod_q;
  logic [32:0]            px_q;
  logic [32:0]            py_q;
  logic signed [31:0]     cx_q;
  logic signed [31:0]     cy_q;
  logic [30:0]            radius_q;
  cps_res_t               out_q;
  logic                   out_valid_q;

  cps_ctl_t               ctl;
  logic signed [XY_W-1:0] x_nx;
  logic signed [XY_W-1:0] y_nx;
  logic signed [Z_W-1:0]  z_nx;
  logic [XY_W-1:0]        ay;
  logic                   below32;
  logic                   below40;
  logic [TURN_W:0]        zsum;
  logic [TURN_W-1:0]      turn_w;
  logic                   flip_w;
  logic signed [31:0]     mul_a;
  logic signed [31:0]     mul_b;
  logic signed [63:0]     prod_d;
  logic                   out_free;
  logic                   in_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // direction: vectoring drives y to zero, rotation drives z to zero
  assign ctl.sigma = (state_q == ST_VEC) ? y_q[XY_W-1] : !z_q[Z_W-1];
  assign ctl.idx   = iter_q;

  cps_cordic_unit u_cordic (
    .ctl_i (ctl),
    .x_i   (x_q),
    .y_i   (y_q),
    .z_i   (z_q),
    .x_o   (x_nx),
    .y_o   (y_nx),
    .z_o   (z_nx)
  );

  // normalize test, x is non-negative here
  assign ay      = y_q[XY_W-1] ? XY_W'(-y_q) : XY_W'(y_q);
  assign below32 = (x_q[XY_W-1:32] == '0) && (ay[XY_W-1:32] == '0);
  assign below40 = (x_q[XY_W-1:40] == '0) && (ay[XY_W-1:40] == '0);

  // vectoring angle rounded to the phase width
  assign zsum = {1'b0, z_q[TURN_W-1:0]} + ((TURN_W + 1)'(1) << (TURN_W - 1 - PHASE_BITS));

  // phase as a turn, folded into the right half plane
  assign turn_w = TURN_W'(phase_q) << (TURN_W - PHASE_BITS);
  assign flip_w = turn_w[TURN_W-1] ^ turn_w[TURN_W-2];

  // shared multiplier: radius times cosine, then sine
  assign mul_a  = $signed({1'b0, radius_q});
  assign mul_b  = (state_q == ST_MULX) ? x_q[31:0] : y_q[31:0];
  assign prod_d = mul_a * mul_b;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_PREP;
      ST_PREP: begin
        if (kind_q == REQ_FROM_POINT && !(x_q == '0 && y_q == '0)) begin
          state_d = ST_NORM;
        end else begin
          state_d = ST_RINIT;
        end
      end
      ST_NORM:  if (!below40) state_d = ST_VEC;
      ST_VEC:   if (iter_q == LAST_STEP) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_RINIT;
      ST_RINIT: state_d = ST_ROT;
      ST_ROT:   if (iter_q == LAST_STEP) state_d = ST_FLIP;
      ST_FLIP:  state_d = ST_MULX;
      ST_MULX:  state_d = ST_MULY;
      ST_MULY:  state_d = ST_PLACE;
      ST_PLACE: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PREP) begin
        case (kind_q)
          REQ_FROM_POINT: if (x_q == '0 && y_q == '0) phase_q <= '0;
          REQ_SET_ANGLE:  phase_q <= PHASE_BITS'(0) - scale_amt(turn_q);
          REQ_STEP_ANGLE: phase_q <= phase_q - scale_amt(turn_q);
          default:        phase_q <= phase_q;
        endcase
      end else if (state_q == ST_ROUND) begin
        phase_q <= zsum[TURN_W-1:TURN_W-PHASE_BITS];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_q <= in_data_i.req_type;
          turn_q <= in_data_i.turn_amount;
          hit_q  <= 1'b0;
          x_q    <= $signed({{(XY_W-32){in_data_i.point_x[31]}}, in_data_i.point_x})
                  - $signed({{(XY_W-32){cx_q[31]}}, cx_q});
          y_q    <= $signed({{(XY_W-32){in_data_i.point_y[31]}}, in_data_i.point_y})
                  - $signed({{(XY_W-32){cy_q[31]}}, cy_q});
        end
      end
      ST_PREP: begin
        if (kind_q == REQ_FROM_POINT) begin
          hit_q <= (x_q == '0 && y_q == '0);
          if (x_q[XY_W-1]) begin
            x_q <= -x_q;
            y_q <= -y_q;
            z_q <= HALF_TURN;
          end else begin
            z_q <= '0;
          end
        end
        iter_q <= '0;
      end
      ST_NORM: begin
        if (below32) begin
          x_q <= x_q <<< 8;
          y_q <= y_q <<< 8;
        end else if (below40) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end
        iter_q <= '0;
      end
      ST_VEC, ST_ROT: begin
        x_q    <= x_nx;
        y_q    <= y_nx;
        z_q    <= z_nx;
        iter_q <= iter_q + IDX_W'(1);
      end
      ST_RINIT: begin
        flip_q <= flip_w;
        x_q    <= $signed({{(XY_W-32){GAIN_Q30[31]}}, GAIN_Q30});
        y_q    <= '0;
        z_q    <= $signed({{(Z_W-TURN_W){turn_w[TURN_W-1] ^ flip_w}},
                           turn_w[TURN_W-1] ^ flip_w, turn_w[TURN_W-2:0]});
        iter_q <= '0;
      end
      ST_FLIP: begin
        if (flip_q) begin
          x_q <= -x_q;
          y_q <= -y_q;
        end
      end
      ST_MULX: prod_q <= prod_d;
      ST_MULY: begin
        px_q   <= place(cx_q, prod_q);
        prod_q <= prod_d;
      end
      ST_PLACE: py_q <= place(cy_q, prod_q);
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CENTRE_X: cx_q     <= cfg_data_i;
        CFG_CENTRE_Y: cy_q     <= cfg_data_i;
        CFG_RADIUS:   radius_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_q.out_x     <= px_q[31:0];
      out_q.out_y     <= py_q[31:0];
      out_q.at_centre <= hit_q;
      out_q.saturated <= px_q[32] | py_q[32];
    end
  end

  `CPS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_fire, state_q == ST_PREP,
                  "sequencer did not start after an accepted request")
  `CPS_ASSERT_NXT(a_done_holds, clk_i, rst_ni,
                  state_q == ST_DONE && out_valid_q && !out_ready_i,
                  state_q == ST_DONE && out_valid_q,
                  "finished result dropped while the receiver stalled")
  `CPS_ASSERT_NOW(a_norm_x_pos, clk_i, rst_ni, state_q == ST_NORM, !x_q[XY_W-1],
                  "vectoring x is negative during normalize")
  `CPS_ASSERT_NXT(a_rot_exit, clk_i, rst_ni,
                  state_q == ST_ROT && iter_q == LAST_STEP, state_q == ST_FLIP,
                  "rotation did not end after the last step")

endmodule
